/* hdl/cdst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coherence directory sharer tracker package
// Field widths, operation codes and shared constants of the directory block.
// ----------------------------------------------------------------------------
package cdst_pkg;

    // Widths of the request and response fields.
    localparam int MODE_W      = 3;
    localparam int SET_IDX_W   = 8;
    localparam int WAY_IDX_W   = 3;
    localparam int SUB_IDX_W   = 2;
    localparam int NODE_W      = 4;
    localparam int OWNER_W     = 4;
    localparam int TOTAL_W     = 5;

    // Configuration port.
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int NODE_CNT_W  = 5;
    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = 5'd16;

    // Register index of node_count, taken from paddr above the byte lane.
    localparam logic REG_NODE_COUNT = 1'b0;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_SET_SHARER = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLR_SHARER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLR_ALL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TEST       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GROUP      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OWNER      = 3'd5;

endpackage

/* hdl/cdst_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory request channel
// Valid/ready channel that carries one directory operation per item.
// ----------------------------------------------------------------------------
interface cdst_req_if;
    import cdst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IDX_W-1:0] way_index;
    logic [SUB_IDX_W-1:0] sub_block;
    logic [NODE_W-1:0]    node;
    logic [OWNER_W-1:0]   new_owner;

    modport source (
        output valid, mode, set_index, way_index, sub_block, node, new_owner,
        input  ready
    );

    modport sink (
        input  valid, mode, set_index, way_index, sub_block, node, new_owner,
        output ready
    );
endinterface

/* hdl/cdst_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory response channel
// Valid/ready channel that carries one result item per directory operation.
// ----------------------------------------------------------------------------
interface cdst_rsp_if;
    import cdst_pkg::*;

    logic               valid;
    logic               ready;
    logic               is_sharer;
    logic               group_busy;
    logic [TOTAL_W-1:0] sharer_total;
    logic [OWNER_W-1:0] owner_out;
    logic               error;

    modport source (
        output valid, is_sharer, group_busy, sharer_total, owner_out, error,
        input  ready
    );

    modport sink (
        input  valid, is_sharer, group_busy, sharer_total, owner_out, error,
        output ready
    );
endinterface

/* hdl/coherence_directory_sharer_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coherence directory sharer tracker
// Full-map directory with a sharer vector, sharer count and owner per entry.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per item (set, clear, clear all, test, group
//   query, owner write); rsp returns exactly one result item for each.
//   node_count is to be written through the APB port only while the block
//   is idle; the block itself does not enforce this. The directory is one
//   single-port memory of SETS*WAYS*SUBBLOCKS entries. A single-entry
//   operation runs through accept, memory read, modify and write back,
//   then load of the output register. The group query walks the SUBBLOCKS
//   entries of its set and way through the same port. req.ready is high
//   only while the sequencer idles. After reset the sequencer sweeps the
//   memory to zero, one entry a cycle, and accepts no item meanwhile;
//   configuration writes are taken at all times.
//   rsp is held in an output register: the next item may be accepted while
//   a result waits, and a finished item waits in its last step until the
//   register is free. A stalled receiver therefore holds the block after one
//   further item.
// ----------------------------------------------------------------------------
module coherence_directory_sharer_tracker_unit #(
    parameter int SETS      = 256,
    parameter int WAYS      = 8,
    parameter int SUBBLOCKS = 4,
    parameter int NODES     = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cdst_req_if.sink                           req,
    cdst_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cdst_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cdst_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cdst_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import cdst_pkg::*;

    localparam int ENTRIES = SETS * WAYS * SUBBLOCKS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BW      = (SUBBLOCKS > 1) ? $clog2(SUBBLOCKS) : 1;
    localparam int NW      = $clog2(NODES);
    localparam int CW      = $clog2(NODES + 1);
    localparam int EW      = NODES + CW + OWNER_W;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [BW-1:0]        sub_cnt_reg, sub_cnt_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [OWNER_W-1:0]   own_reg, own_next;
    logic [NODE_CNT_W-1:0] node_count_reg, node_count_next;

    // Result held between the modify step and the output register.
    logic                 res_sharer_reg, res_sharer_next;
    logic                 res_busy_reg, res_busy_next;
    logic [TOTAL_W-1:0]   res_total_reg, res_total_next;
    logic [OWNER_W-1:0]   res_owner_reg, res_owner_next;
    logic                 res_err_reg, res_err_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic                 out_sharer_reg, out_sharer_next;
    logic                 out_busy_reg, out_busy_next;
    logic [TOTAL_W-1:0]   out_total_reg, out_total_next;
    logic [OWNER_W-1:0]   out_owner_reg, out_owner_next;
    logic                 out_err_reg, out_err_next;

    // Directory memory and its port.
    logic [EW-1:0]        dir_mem [ENTRIES];
    logic [EW-1:0]        rd_data_reg;
    logic [AW-1:0]        mem_addr;
    logic                 mem_we;
    logic [EW-1:0]        mem_wdata;

    // Index wrap tables, worked out at elaboration.
    logic [SW-1:0]        set_wrap [2**SET_IDX_W];
    logic [WW-1:0]        way_wrap [2**WAY_IDX_W];
    logic [BW-1:0]        sub_wrap [2**SUB_IDX_W];

    for (genvar g = 0; g < 2**SET_IDX_W; g++) begin : g_set_wrap
        assign set_wrap[g] = SW'(g % SETS);
    end
    for (genvar g = 0; g < 2**WAY_IDX_W; g++) begin : g_way_wrap
        assign way_wrap[g] = WW'(g % WAYS);
    end
    for (genvar g = 0; g < 2**SUB_IDX_W; g++) begin : g_sub_wrap
        assign sub_wrap[g] = BW'(g % SUBBLOCKS);
    end

    // Fields of the entry read back from the memory.
    logic [NODES-1:0]     rd_bits;
    logic [CW-1:0]        rd_cnt;
    logic [OWNER_W-1:0]   rd_own;
    logic [NW-1:0]        node_idx;
    logic [NODES-1:0]     node_bit;
    logic                 hit;
    logic                 node_over;
    logic                 node_bad;
    logic                 own_bad;
    logic [AW-1:0]        req_addr;
    logic                 req_fire;
    logic                 out_free;

    assign rd_bits  = rd_data_reg[EW-1 -: NODES];
    assign rd_cnt   = rd_data_reg[OWNER_W +: CW];
    assign rd_own   = rd_data_reg[OWNER_W-1:0];
    assign node_idx = NW'(node_reg);
    assign node_bit = {{(NODES-1){1'b0}}, 1'b1} << node_idx;
    assign hit      = rd_bits[node_idx];

    // Range checks against the node limit, min(node_count, NODES).
    assign node_over = ({1'b0, node_reg} >= node_count_reg) || (int'(node_reg) >= NODES);
    assign node_bad  = (node_reg == '0) || node_over;
    assign own_bad   = (own_reg != '0)
                       && (({1'b0, own_reg} >= node_count_reg) || (int'(own_reg) >= NODES));

    // Entry address of the request; the group query starts at sub-block zero.
    always_comb
    begin
        logic [BW-1:0] sub_w;
        sub_w = (req.mode == MODE_GROUP) ? '0 : sub_wrap[req.sub_block];
        req_addr = AW'((AW'(set_wrap[req.set_index]) * AW'(WAYS)
                        + AW'(way_wrap[req.way_index])) * AW'(SUBBLOCKS)
                       + AW'(sub_w));
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Sequencer and the shared modify unit.
    always_comb
    begin
        logic [NODES-1:0] new_bits;
        logic [CW-1:0]    new_cnt;
        logic [OWNER_W-1:0] new_own;

        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        addr_next       = addr_reg;
        sub_cnt_next    = sub_cnt_reg;
        mode_next       = mode_reg;
        node_next       = node_reg;
        own_next        = own_reg;
        res_sharer_next = res_sharer_reg;
        res_busy_next   = res_busy_reg;
        res_total_next  = res_total_reg;
        res_owner_next  = res_owner_reg;
        res_err_next    = res_err_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_sharer_next = out_sharer_reg;
        out_busy_next   = out_busy_reg;
        out_total_next  = out_total_reg;
        out_owner_next  = out_owner_reg;
        out_err_next    = out_err_reg;
        mem_addr        = addr_reg;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        new_bits        = rd_bits;
        new_cnt         = rd_cnt;
        new_own         = rd_own;

        case (state_reg)
            // Sweep the memory to zero after reset.
            ST_CLEAR:
            begin
                mem_addr = clr_cnt_reg;
                mem_we   = 1'b1;
                if (clr_cnt_reg == AW'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            // Take in a request.
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    addr_next     = req_addr;
                    sub_cnt_next  = '0;
                    mode_next     = req.mode;
                    node_next     = req.node;
                    own_next      = req.new_owner;
                    res_busy_next = 1'b0;
                    state_next    = ST_READ;
                end
            end

            // Memory read; data lands in rd_data_reg.
            ST_READ:
            begin
                state_next = ST_EVAL;
            end

            // Modify and write back, or accumulate the group query.
            ST_EVAL:
            begin
                res_sharer_next = 1'b0;
                res_err_next    = 1'b0;
                if (mode_reg == MODE_GROUP)
                begin
                    res_busy_next  = res_busy_reg || (rd_cnt != '0) || (rd_own != '0);
                    res_total_next = '0;
                    res_owner_next = '0;
                    if (sub_cnt_reg == BW'(SUBBLOCKS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sub_cnt_next = sub_cnt_reg + 1'b1;
                        addr_next    = addr_reg + 1'b1;
                        state_next   = ST_READ;
                    end
                end
                else
                begin
                    res_busy_next = 1'b0;
                    case (mode_reg)
                        MODE_SET_SHARER:
                        begin
                            if (node_bad)
                            begin
                                res_err_next = 1'b1;
                            end
                            else if (!hit)
                            begin
                                new_bits = rd_bits | node_bit;
                                new_cnt  = rd_cnt + 1'b1;
                            end
                        end
                        MODE_CLR_SHARER:
                        begin
                            if (node_bad)
                            begin
                                res_err_next = 1'b1;
                            end
                            else if (hit)
                            begin
                                new_bits = rd_bits & ~node_bit;
                                if (rd_cnt != '0)
                                begin
                                    new_cnt = rd_cnt - 1'b1;
                                end
                            end
                        end
                        MODE_CLR_ALL:
                        begin
                            new_bits = '0;
                            new_cnt  = '0;
                        end
                        MODE_TEST:
                        begin
                            if (node_over)
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                res_sharer_next = hit;
                            end
                        end
                        MODE_OWNER:
                        begin
                            if (own_bad)
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                new_own = own_reg;
                            end
                        end
                        default:
                        begin
                            res_err_next = 1'b1;
                        end
                    endcase
                    mem_we         = 1'b1;
                    mem_wdata      = {new_bits, new_cnt, new_own};
                    res_total_next = TOTAL_W'(new_cnt);
                    res_owner_next = new_own;
                    state_next     = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sharer_next = res_sharer_reg;
                    out_busy_next   = res_busy_reg;
                    out_total_next  = res_total_reg;
                    out_owner_next  = res_owner_reg;
                    out_err_next    = res_err_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration register write.
    always_comb
    begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && pready
            && (paddr[APB_ADDR_W-1] == REG_NODE_COUNT))
        begin
            node_count_next = pwdata[NODE_CNT_W-1:0];
        end
    end

    // Configuration register read.
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_NODE_COUNT)
                    ? APB_DATA_W'(node_count_reg) : '0;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            node_count_reg <= NODE_CNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
            node_count_reg <= node_count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        sub_cnt_reg    <= sub_cnt_next;
        mode_reg       <= mode_next;
        node_reg       <= node_next;
        own_reg        <= own_next;
        res_sharer_reg <= res_sharer_next;
        res_busy_reg   <= res_busy_next;
        res_total_reg  <= res_total_next;
        res_owner_reg  <= res_owner_next;
        res_err_reg    <= res_err_next;
        out_sharer_reg <= out_sharer_next;
        out_busy_reg   <= out_busy_next;
        out_total_reg  <= out_total_next;
        out_owner_reg  <= out_owner_next;
        out_err_reg    <= out_err_next;
    end

    // Directory memory: one port, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dir_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= dir_mem[mem_addr];
    end

    // Response channel.
    assign rsp.valid        = out_valid_reg;
    assign rsp.is_sharer    = out_sharer_reg;
    assign rsp.group_busy   = out_busy_reg;
    assign rsp.sharer_total = out_total_reg;
    assign rsp.owner_out    = out_owner_reg;
    assign rsp.error        = out_err_reg;

endmodule
